/* rtl/kss_pkg.sv */
// Package for the k-smallest selector: widths, parameter defaults and the
// drain-row control struct. No dependencies.
package kss_pkg;

  localparam int K_MAX_DEF      = 16;
  localparam int INDEX_BITS_DEF = 16;
  localparam int DIST_W         = 32;
  localparam int KCFG_W         = 5;
  localparam int RANK_W         = 4;

  localparam logic [KCFG_W-1:0] K_IN_USE_RESET = KCFG_W'(16);

  typedef struct packed {
    logic load;   // take a whole sorted list from the insertion row
    logic shift;  // move every entry one place toward the output
  } drain_ctrl_t;

endpackage

/* rtl/kss_cell.sv */
// One slot of the sorted insertion row of the k-smallest selector.
// Uses kss_pkg; instantiated by k_smallest_selector.
module kss_cell #(
  parameter int POS        = 0,
  parameter int INDEX_BITS = kss_pkg::INDEX_BITS_DEF,
  parameter int CNT_W      = 5
) (
  input  logic                      clk,
  input  logic                      accept,
  input  logic                      ins,
  input  logic [CNT_W-1:0]          cnt_eff,
  input  logic [kss_pkg::DIST_W-1:0] new_dist,
  input  logic [INDEX_BITS-1:0]     new_idx,
  input  logic                      left_gt,
  input  logic [kss_pkg::DIST_W-1:0] left_dist,
  input  logic [INDEX_BITS-1:0]     left_idx,
  output logic                      gt,
  output logic [kss_pkg::DIST_W-1:0] slot_dist,
  output logic [INDEX_BITS-1:0]     idx,
  output logic [kss_pkg::DIST_W-1:0] dist_next,
  output logic [INDEX_BITS-1:0]     idx_next
);

  logic occupied;
  logic take_new;

  assign occupied = CNT_W'(POS) < cnt_eff;
  assign gt       = occupied && (slot_dist > new_dist);
  // the new entry lands at the first slot larger than it, or at the tail
  assign take_new = !left_gt && (gt || (CNT_W'(POS) == cnt_eff));

  always_comb begin
    dist_next = slot_dist;
    idx_next  = idx;
    if (ins) begin
      if (left_gt) begin
        dist_next = left_dist;
        idx_next  = left_idx;
      end else if (take_new) begin
        dist_next = new_dist;
        idx_next  = new_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slot_dist <= dist_next;
      idx       <= idx_next;
    end
  end

endmodule

/* rtl/kss_drain_cell.sv */
// One slot of the output drain row: loads a finished list in parallel,
// then shifts toward slot 0 as results are taken. Uses kss_pkg.
module kss_drain_cell #(
  parameter int INDEX_BITS = kss_pkg::INDEX_BITS_DEF
) (
  input  logic                       clk,
  input  kss_pkg::drain_ctrl_t       ctrl,
  input  logic [kss_pkg::DIST_W-1:0] load_dist,
  input  logic [INDEX_BITS-1:0]      load_idx,
  input  logic [kss_pkg::DIST_W-1:0] right_dist,
  input  logic [INDEX_BITS-1:0]      right_idx,
  output logic [kss_pkg::DIST_W-1:0] slot_dist,
  output logic [INDEX_BITS-1:0]      idx
);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      slot_dist <= load_dist;
      idx       <= load_idx;
    end else if (ctrl.shift) begin
      slot_dist <= right_dist;
      idx       <= right_idx;
    end
  end

endmodule

/* rtl/k_smallest_selector.sv */
// Top level of the k-smallest selector: insertion row of kss_cell slots
// and output drain row of kss_drain_cell slots. Uses kss_pkg.
//
// Usage: candidates (distance, cand_index, first_of_query, last_of_query)
// arrive on the in_valid/in_ready channel, one transaction per cycle. Each
// candidate is compared against every kept slot at once and inserted by a
// one-step shift of the row, so a candidate is taken every cycle unless held
// off as below. On a candidate marked last_of_query the sorted list is copied
// into the drain row in the same cycle and the insertion row starts empty for
// the next query. Results leave on out_valid/out_ready from the cycle after
// that candidate, one per cycle, nearest first, one result per kept entry, so
// up to k per query (k is the configured count, limited to 1..K_MAX);
// last_result marks the final one.
// While the drain row still holds results, a new last_of_query candidate is
// held off (in_ready low for it only); other candidates keep flowing. A
// stalled receiver just holds the drain row. The user is to write k_in_use
// through cfg_write_en/cfg_write_data while idle; the block itself leaves this
// to the user. Reset empties both rows and sets k_in_use to 16.
module k_smallest_selector #(
  parameter int K_MAX      = kss_pkg::K_MAX_DEF,
  parameter int INDEX_BITS = kss_pkg::INDEX_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write_en,
  input  logic [kss_pkg::KCFG_W-1:0]    cfg_write_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [kss_pkg::DIST_W-1:0]    distance,
  input  logic [INDEX_BITS-1:0]         cand_index,
  input  logic                          first_of_query,
  input  logic                          last_of_query,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [kss_pkg::RANK_W-1:0]    rank,
  output logic [kss_pkg::DIST_W-1:0]    nearest_distance,
  output logic [INDEX_BITS-1:0]         nearest_index,
  output logic                          last_result
);

  localparam int CNT_W = $clog2(K_MAX + 1);
  localparam int IW    = (K_MAX > 1) ? $clog2(K_MAX) : 1;

  logic [kss_pkg::KCFG_W-1:0] k_in_use;
  logic [CNT_W-1:0]           cnt;
  logic [CNT_W-1:0]           out_cnt;
  logic [CNT_W-1:0]           out_rank;

  logic [CNT_W-1:0] kef;
  logic [CNT_W-1:0] cnt_eff;
  logic [CNT_W-1:0] cnt_after;
  logic             accept;
  logic             full;
  logic             ins;

  logic [K_MAX-1:0]                gt;
  logic [kss_pkg::DIST_W-1:0]      c_dist      [K_MAX];
  logic [INDEX_BITS-1:0]           c_idx       [K_MAX];
  logic [kss_pkg::DIST_W-1:0]      c_dist_next [K_MAX];
  logic [INDEX_BITS-1:0]           c_idx_next  [K_MAX];
  logic [kss_pkg::DIST_W-1:0]      d_dist      [K_MAX];
  logic [INDEX_BITS-1:0]           d_idx       [K_MAX];
  kss_pkg::drain_ctrl_t            dctrl;

  // clamp configured k into 1..K_MAX
  always_comb begin
    if (k_in_use == '0) begin
      kef = CNT_W'(1);
    end else if (32'(k_in_use) > K_MAX) begin
      kef = CNT_W'(K_MAX);
    end else begin
      kef = CNT_W'(k_in_use);
    end
  end

  always_comb begin
    if (first_of_query) begin
      cnt_eff = '0;
    end else if (cnt > kef) begin
      cnt_eff = kef;
    end else begin
      cnt_eff = cnt;
    end
  end

  assign full      = (cnt_eff == kef);
  assign ins       = !full || gt[IW'(kef - CNT_W'(1))];
  assign cnt_after = full ? cnt_eff : cnt_eff + CNT_W'(1);

  assign in_ready = !(last_of_query && (out_cnt != '0));
  assign accept   = in_valid && in_ready;

  assign out_valid        = (out_cnt != '0);
  assign rank             = kss_pkg::RANK_W'(out_rank);
  assign nearest_distance = d_dist[0];
  assign nearest_index    = d_idx[0];
  assign last_result      = (out_cnt == CNT_W'(1));

  assign dctrl.load  = accept && last_of_query;
  assign dctrl.shift = out_valid && out_ready;

  for (genvar i = 0; i < K_MAX; i++) begin : g_row
    kss_cell #(
      .POS        (i),
      .INDEX_BITS (INDEX_BITS),
      .CNT_W      (CNT_W)
    ) u_cell (
      .clk       (clk),
      .accept    (accept),
      .ins       (ins),
      .cnt_eff   (cnt_eff),
      .new_dist  (distance),
      .new_idx   (cand_index),
      .left_gt   ((i == 0) ? 1'b0 : gt[(i == 0) ? 0 : i - 1]),
      .left_dist (c_dist[(i == 0) ? 0 : i - 1]),
      .left_idx  (c_idx[(i == 0) ? 0 : i - 1]),
      .gt        (gt[i]),
      .slot_dist (c_dist[i]),
      .idx       (c_idx[i]),
      .dist_next (c_dist_next[i]),
      .idx_next  (c_idx_next[i])
    );

    kss_drain_cell #(
      .INDEX_BITS (INDEX_BITS)
    ) u_drain (
      .clk        (clk),
      .ctrl       (dctrl),
      .load_dist  (c_dist_next[i]),
      .load_idx   (c_idx_next[i]),
      .right_dist (d_dist[(i == K_MAX - 1) ? i : i + 1]),
      .right_idx  (d_idx[(i == K_MAX - 1) ? i : i + 1]),
      .slot_dist  (d_dist[i]),
      .idx        (d_idx[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k_in_use <= kss_pkg::K_IN_USE_RESET;
      cnt      <= '0;
      out_cnt  <= '0;
      out_rank <= '0;
    end else begin
      if (cfg_write_en) begin
        k_in_use <= cfg_write_data;
      end
      if (accept) begin
        cnt <= last_of_query ? '0 : cnt_after;
      end
      // load a finished list, otherwise advance on each taken result
      if (dctrl.load) begin
        out_cnt  <= cnt_after;
        out_rank <= '0;
      end else if (dctrl.shift) begin
        out_cnt  <= out_cnt - CNT_W'(1);
        out_rank <= out_rank + CNT_W'(1);
      end
    end
  end

endmodule
